// ===== rtl/ebc_pkg.sv =====
// ebc_pkg: shared types, widths and build-time binomial helpers for the
// enumerative block codec. No dependencies.
package ebc_pkg;

    localparam int BLOCK_BITS_DEF = 15;
    localparam int BINOM_ROWS     = 64;

    // field widths
    localparam int CMD_W = 1;
    localparam int BLK_W = 15;
    localparam int CLS_W = 4;
    localparam int OFF_W = 13;
    localparam int LEN_W = 4;
    localparam int IDX_W = 4;

    // slave tdata layout
    localparam int S_BLK_LSB = 0;
    localparam int S_CLS_LSB = S_BLK_LSB + BLK_W;
    localparam int S_OFF_LSB = S_CLS_LSB + CLS_W;
    localparam int S_IDX_LSB = S_OFF_LSB + OFF_W;
    localparam int S_USED_W  = S_IDX_LSB + IDX_W;
    localparam int S_DATA_W  = ((S_USED_W + 7) / 8) * 8;

    // master tdata layout
    localparam int M_USED_W = CLS_W + OFF_W + LEN_W + 1;
    localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - M_USED_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    // payload that walks down the cell chain
    typedef struct packed {
        cmd_t             cmd;
        logic [BLK_W-1:0] blk;
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] enc_off;
        logic [CLS_W-1:0] dec_k;
        logic [OFF_W-1:0] dec_off;
        logic             dec_bit;
    } cell_data_t;

    // C(m,k) from Pascal's triangle, zero for k > m
    function automatic logic [63:0] binom(input int m, input int k);
        logic [63:0] row [BINOM_ROWS];
        for (int j = 0; j < BINOM_ROWS; j++) begin
            row[j] = '0;
        end
        row[0] = 64'd1;
        for (int i = 1; i <= m && i < BINOM_ROWS; i++) begin
            for (int j = i; j >= 1; j--) begin
                row[j] = row[j] + row[j-1];
            end
        end
        if (m < 0 || k < 0 || m >= BINOM_ROWS || k > m) begin
            return '0;
        end
        return row[k];
    endfunction

    // C(m,k) modulo the offset field
    function automatic logic [OFF_W-1:0] binom_mod(input int m, input int k);
        logic [63:0] b;
        b = binom(m, k);
        return b[OFF_W-1:0];
    endfunction

    // C(m,k) saturated at 2^OFF_W, enough for compares against an offset
    function automatic logic [OFF_W:0] binom_sat(input int m, input int k);
        logic [63:0] b;
        b = binom(m, k);
        if (b >= (64'd1 << OFF_W)) begin
            return (OFF_W+1)'(1) << OFF_W;
        end
        return b[OFF_W:0];
    endfunction

    function automatic int ceil_log2(input logic [63:0] c);
        int len;
        len = 0;
        while (len < 63 && (64'd1 << len) < c) begin
            len++;
        end
        return len;
    endfunction

endpackage

// ===== rtl/ebc_cell.sv =====
// ebc_cell: one position of the codec chain; one encode rank step and one
// decode walk step, registered. Depends on ebc_pkg.
module ebc_cell import ebc_pkg::*; #(
    parameter int N     = BLOCK_BITS_DEF,
    parameter int I     = 0,
    parameter int CNT_W = $clog2(BLOCK_BITS_DEF + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             valid_in,
    input  cell_data_t       data_in,
    input  logic [CNT_W-1:0] cnt_in,
    output logic             valid_out,
    output cell_data_t       data_out,
    output logic [CNT_W-1:0] cnt_out
);

    // encode walks positions from the top down, decode from the bottom up
    localparam int   EP     = N - 1 - I;
    localparam int   CN     = 2 ** CNT_W;
    localparam int   KN     = 2 ** CLS_W;
    localparam logic HIT_OK = (I < 2 ** IDX_W);

    logic [OFF_W-1:0] enc_tab [CN];
    logic [OFF_W:0]   dec_tab [KN];
    logic             e_bit;
    logic             hit;
    logic [OFF_W:0]   dec_c;
    logic             dec_take;

    cell_data_t       data_reg, data_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg;

    // C(I, ones seen above + 1) for a set bit
    for (genvar j = 0; j < CN; j++) begin : g_enc_tab
        assign enc_tab[j] = binom_mod(I, j + 1);
    end

    // C(N-1-I, k) for the decode compare
    for (genvar j = 0; j < KN; j++) begin : g_dec_tab
        assign dec_tab[j] = binom_sat(N - 1 - I, j);
    end

    if (EP < BLK_W) begin : g_bit
        assign e_bit = data_in.blk[EP];
    end else begin : g_no_bit
        assign e_bit = 1'b0;
    end

    assign hit = HIT_OK && (data_in.idx == IDX_W'(I));

    always_comb begin
        data_next = data_in;
        cnt_next  = cnt_in;
        dec_c     = dec_tab[data_in.dec_k];
        dec_take  = (data_in.dec_k != '0) && ({1'b0, data_in.dec_off} >= dec_c);
        if (e_bit) begin
            data_next.enc_off = data_in.enc_off + enc_tab[cnt_in];
            cnt_next          = cnt_in + CNT_W'(1);
        end
        if (dec_take) begin
            data_next.dec_off = data_in.dec_off - dec_c[OFF_W-1:0];
            data_next.dec_k   = data_in.dec_k - CLS_W'(1);
        end
        if (hit) begin
            data_next.dec_bit = dec_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
    assign cnt_out   = cnt_reg;

endmodule

// ===== rtl/enumerative_block_codec.sv =====
// enumerative_block_codec: top level of the (class, offset) block codec,
// a chain of ebc_cell stages. Depends on ebc_pkg and ebc_cell.
//
// usage
// - slave channel: one transaction is one command; s_tuser selects encode
//   or decode, s_tdata carries the block, class, offset and bit index
// - master channel: one transaction per command with class, offset and
//   offset length (encode) or the decoded bit (decode); unused fields are 0
// - pipeline: one cell register per block position lies between the slave
//   transaction and m_tvalid
// - throughput: one command per cycle unless a stall holds the chain; the
//   BLOCK_BITS cells are fully pipelined, each registers its step on advance
// - stall: while m_tvalid is high and m_tready low the whole chain holds
//   and s_tready is low; bubbles are not squeezed out during a stall
// - reset: aresetn low clears all stage valids, the chain is empty and
//   ready on the first cycle after reset
module enumerative_block_codec import ebc_pkg::*; #(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // block_bits[14:0], class_in[18:15], offset_in[31:19], bit_index[35:32]
    input  logic [S_DATA_W-1:0] s_tdata,
    // command[0]
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // class_out[3:0], offset_out[16:4], offset_length[20:17], bit_out[21]
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(BLOCK_BITS + 1);
    localparam int CN    = 2 ** CNT_W;

    // index 0 is the slave side, index BLOCK_BITS the last cell register
    logic             valid_c [BLOCK_BITS+1];
    cell_data_t       data_c  [BLOCK_BITS+1];
    logic [CNT_W-1:0] cnt_c   [BLOCK_BITS+1];

    logic             adv;
    logic [LEN_W-1:0] len_tab [CN];
    cell_data_t       last;
    logic [CNT_W-1:0] cnt_last;
    logic             is_enc;
    logic [CLS_W-1:0] class_out;
    logic [OFF_W-1:0] offset_out;
    logic [LEN_W-1:0] offset_length;
    logic             bit_out;

    // the chain moves whenever the output slot is free or being taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // unpack the slave transaction into the head of the chain
    assign valid_c[0]         = s_tvalid;
    assign data_c[0].cmd      = cmd_t'(s_tuser[0]);
    assign data_c[0].blk      = s_tdata[S_BLK_LSB +: BLK_W];
    assign data_c[0].idx      = s_tdata[S_IDX_LSB +: IDX_W];
    assign data_c[0].enc_off  = '0;
    assign data_c[0].dec_k    = s_tdata[S_CLS_LSB +: CLS_W];
    assign data_c[0].dec_off  = s_tdata[S_OFF_LSB +: OFF_W];
    assign data_c[0].dec_bit  = 1'b0;
    assign cnt_c[0]           = '0;

    for (genvar i = 0; i < BLOCK_BITS; i++) begin : g_cell
        ebc_cell #(
            .N     (BLOCK_BITS),
            .I     (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (valid_c[i]),
            .data_in   (data_c[i]),
            .cnt_in    (cnt_c[i]),
            .valid_out (valid_c[i+1]),
            .data_out  (data_c[i+1]),
            .cnt_out   (cnt_c[i+1])
        );
    end

    // offset length per class, ceil(log2 C(BLOCK_BITS, class))
    for (genvar j = 0; j < CN; j++) begin : g_len_tab
        assign len_tab[j] = LEN_W'(ceil_log2(binom(BLOCK_BITS, j)));
    end

    assign last     = data_c[BLOCK_BITS];
    assign cnt_last = cnt_c[BLOCK_BITS];
    assign is_enc   = (last.cmd == CMD_ENCODE);

    // fields of the other command read as zero
    assign class_out     = is_enc ? CLS_W'(cnt_last) : '0;
    assign offset_out    = is_enc ? last.enc_off : '0;
    assign offset_length = is_enc ? len_tab[cnt_last] : '0;
    assign bit_out       = is_enc ? 1'b0 : last.dec_bit;

    assign m_tvalid = valid_c[BLOCK_BITS];
    assign m_tdata  = {{M_PAD_W{1'b0}}, bit_out, offset_length, offset_out, class_out};

`ifndef SYNTHESIS
    // population count never exceeds the block size
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && is_enc |-> (int'(cnt_last) <= BLOCK_BITS))
        else $error("encode class beyond block size");

    // an empty block ranks zero
    a_empty_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && is_enc && (cnt_last == '0) |-> (last.enc_off == '0))
        else $error("nonzero rank for empty block");

    // an index past the block never hits a cell
    a_idx_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !is_enc && (int'(last.idx) >= BLOCK_BITS) |-> !last.dec_bit)
        else $error("decoded bit set for index outside block");

    // a stalled chain keeps its last stage
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> m_tvalid && $stable(cnt_last) && $stable(last))
        else $error("last stage changed during stall");
`endif

endmodule

// ===== test/enumerative_block_codec_tb.sv =====
// enumerative_block_codec_tb: self-checking bench for the (class, offset) block codec,
// with its own binomial table predictor and an in-order result scoreboard.
// Depends on ebc_pkg and the enumerative_block_codec rtl.
`timescale 1ns / 1ps

module enumerative_block_codec_tb;
    import ebc_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_CYC   = 7;
    localparam int NPOS        = BLOCK_BITS_DEF;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 200000;

    // one expected master transaction, unpacked
    typedef struct {
        logic [CLS_W-1:0] cls;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic             dbit;
    } codec_result_t;

    // predicts every command and holds the results still owed by the chain
    class codec_scoreboard;
        longint unsigned pascal [NPOS+1][NPOS+1];
        codec_result_t   owed_q [$];
        int              mismatches;

        function new();
            for (int m = 0; m <= NPOS; m++) begin
                for (int k = 0; k <= NPOS; k++) begin
                    pascal[m][k] = 0;
                end
            end
            for (int m = 0; m <= NPOS; m++) begin
                pascal[m][0] = 1;
                for (int k = 1; k <= m; k++) begin
                    pascal[m][k] = pascal[m-1][k-1] + pascal[m-1][k];
                end
            end
            mismatches = 0;
        endfunction

        // popcount, rank within class and offset length of one block
        function codec_result_t encode_block(logic [BLK_W-1:0] blk);
            codec_result_t   r;
            int              ones;
            int              left;
            int              len;
            longint unsigned rank;
            ones = $countones(blk);
            left = ones;
            rank = 0;
            for (int p = 0; p < NPOS; p++) begin
                // stop once no ones remain or every remaining position is a one
                if (left == 0 || left > NPOS - p - 1) begin
                    break;
                end
                if (blk[p]) begin
                    rank += pascal[NPOS-p-1][left];
                    left--;
                end
            end
            len = 0;
            while (len < 63 && (64'd1 << len) < pascal[NPOS][ones]) begin
                len++;
            end
            r.cls  = CLS_W'(ones);
            r.off  = rank[OFF_W-1:0];
            r.len  = LEN_W'(len);
            r.dbit = 1'b0;
            return r;
        endfunction

        // walk the offset down and return the bit at one position
        function codec_result_t decode_bit(logic [CLS_W-1:0] cls, logic [OFF_W-1:0] off,
                                           logic [IDX_W-1:0] idx);
            codec_result_t   r;
            int              k;
            longint unsigned rest;
            longint unsigned c;
            logic            b;
            r.cls  = '0;
            r.off  = '0;
            r.len  = '0;
            r.dbit = 1'b0;
            k      = cls;
            rest   = off;
            for (int p = 0; p < NPOS; p++) begin
                if (k == 0) begin
                    break;
                end
                // a class beyond the remaining positions sees a zero coefficient
                c = (k > NPOS - p - 1) ? 0 : pascal[NPOS-p-1][k];
                b = 1'b0;
                if (rest >= c) begin
                    rest -= c;
                    k--;
                    b = 1'b1;
                end
                if (p == idx) begin
                    r.dbit = b;
                    break;
                end
            end
            return r;
        endfunction

        function void note_command(cmd_t cmd, logic [S_DATA_W-1:0] data);
            if (cmd == CMD_ENCODE) begin
                owed_q.insert(owed_q.size(), encode_block(data[S_BLK_LSB +: BLK_W]));
            end else begin
                owed_q.insert(owed_q.size(), decode_bit(data[S_CLS_LSB +: CLS_W],
                                                        data[S_OFF_LSB +: OFF_W],
                                                        data[S_IDX_LSB +: IDX_W]));
            end
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [M_DATA_W-1:0] data);
            codec_result_t e;
            logic [CLS_W-1:0] cls;
            logic [OFF_W-1:0] off;
            logic [LEN_W-1:0] len;
            logic             dbit;
            cls  = data[0 +: CLS_W];
            off  = data[CLS_W +: OFF_W];
            len  = data[CLS_W+OFF_W +: LEN_W];
            dbit = data[CLS_W+OFF_W+LEN_W];
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result tdata=%h", data));
                return;
            end
            e = owed_q.pop_front();
            if (cls !== e.cls) begin
                report($sformatf("class_out %0d, expected %0d", cls, e.cls));
            end
            if (off !== e.off) begin
                report($sformatf("offset_out %0d, expected %0d", off, e.off));
            end
            if (len !== e.len) begin
                report($sformatf("offset_length %0d, expected %0d", len, e.len));
            end
            if (dbit !== e.dbit) begin
                report($sformatf("bit_out %b, expected %b", dbit, e.dbit));
            end
        endtask
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = CMD_ENCODE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    codec_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles        = 0;

    enumerative_block_codec #(
        .BLOCK_BITS(BLOCK_BITS_DEF)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // receiver backpressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // both channels are sampled at the rising edge, before the chain updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_command(cmd_t'(s_tuser), s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one slave transaction: optional idle gap, then hold until accepted
    task automatic send_command(cmd_t cmd, logic [BLK_W-1:0] blk, logic [CLS_W-1:0] cls,
                                logic [OFF_W-1:0] off, logic [IDX_W-1:0] idx);
        logic [S_DATA_W-1:0] data;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        data = '0;
        data[S_BLK_LSB +: BLK_W] = blk;
        data[S_CLS_LSB +: CLS_W] = cls;
        data[S_OFF_LSB +: OFF_W] = off;
        data[S_IDX_LSB +: IDX_W] = idx;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    // sender stays quiet until every owed result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // a third fully random blocks, the rest with a chosen density so every class shows up
    function automatic logic [BLK_W-1:0] pick_block();
        logic [BLK_W-1:0] blk;
        int               k;
        if ($urandom_range(0, 2) == 0) begin
            return BLK_W'($urandom);
        end
        blk = '0;
        k   = $urandom_range(0, NPOS);
        for (int i = 0; i < k; i++) begin
            blk[$urandom_range(0, NPOS-1)] = 1'b1;
        end
        return blk;
    endfunction

    task automatic send_random();
        int               pick;
        logic [BLK_W-1:0] blk;
        codec_result_t    enc;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // encode, unused fields carry noise
            send_command(CMD_ENCODE, pick_block(), CLS_W'($urandom), OFF_W'($urandom),
                         IDX_W'($urandom));
        end else if (pick < 85) begin
            // decode of a real (class, offset) pair
            blk = pick_block();
            enc = sb.encode_block(blk);
            send_command(CMD_DECODE, BLK_W'($urandom), enc.cls, enc.off,
                         IDX_W'($urandom_range(0, NPOS)));
        end else begin
            // decode with arbitrary class and offset
            send_command(CMD_DECODE, BLK_W'($urandom), CLS_W'($urandom), OFF_W'($urandom),
                         IDX_W'($urandom));
        end
    endtask

    task automatic run_directed();
        // encode: empty, full, lone ends, alternating, densest ranks
        send_command(CMD_ENCODE, 15'h0000, '0, '0, '0);
        send_command(CMD_ENCODE, 15'h7fff, '1, '1, '1);
        send_command(CMD_ENCODE, 15'h0001, '0, '0, '0);
        send_command(CMD_ENCODE, 15'h4000, '0, '0, '0);
        send_command(CMD_ENCODE, 15'h5555, '0, '0, '0);
        send_command(CMD_ENCODE, 15'h2aaa, '1, '1, '1);
        send_command(CMD_ENCODE, 15'h007f, '0, '0, '0);
        send_command(CMD_ENCODE, 15'h00ff, '0, '0, '0);
        send_command(CMD_ENCODE, 15'h7f00, '0, '0, '0);
        send_command(CMD_ENCODE, 15'h3fff, '0, '0, '0);
        // decode: class zero yields nothing
        send_command(CMD_DECODE, '1, 4'd0, '0, 4'd0);
        send_command(CMD_DECODE, '0, 4'd0, 13'd1234, 4'd5);
        // decode: first and last position, top rank of the widest class
        send_command(CMD_DECODE, '0, 4'd7, 13'd6434, 4'd0);
        send_command(CMD_DECODE, '0, 4'd7, 13'd6434, 4'd14);
        send_command(CMD_DECODE, '0, 4'd1, 13'd0, 4'd14);
        send_command(CMD_DECODE, '0, 4'd14, 13'd0, 4'd14);
        // bit index past the block
        send_command(CMD_DECODE, '0, 4'd7, 13'd100, 4'd15);
        // class equal to block size, then offsets beyond and within the class
        send_command(CMD_DECODE, '1, 4'd15, 13'd8191, 4'd14);
        send_command(CMD_DECODE, '0, 4'd15, 13'd0, 4'd3);
        send_command(CMD_DECODE, '0, 4'd7, 13'd8191, 4'd7);
        send_command(CMD_DECODE, '0, 4'd2, 13'd8191, 4'd1);
        send_command(CMD_DECODE, '0, 4'd8, 13'd3000, 4'd9);
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYC) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // slow receiver
        send_idle_pct = 36;
        recv_idle_pct = 87;
        run_directed();
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random();
        end
        drain();

        // slow sender
        send_idle_pct = 87;
        recv_idle_pct = 36;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random();
        end
        drain();

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random();
        end
        drain();

        // let any stray transaction out of the chain
        repeat (NPOS + 20) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ebc_pkg.sv
rtl/ebc_cell.sv
rtl/enumerative_block_codec.sv
test/enumerative_block_codec_tb.sv
